/* design/bsp_pkg.sv */
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the background subtraction pixel pipeline.
// ----------------------------------------------------------------------------
package bsp_pkg;

  // Frame geometry and background store addressing.
  localparam int FRAME_PIXELS = 76800;
  localparam int IDX_W        = 17;

  // Gray conversion: (11R + 16G + 5B) >> 5.
  localparam int        GRAY_SUM_W    = 13;
  localparam int        GRAY_SHIFT    = 5;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WEIGHT_R = 13'd11;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WEIGHT_G = 13'd16;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WEIGHT_B = 13'd5;

  localparam logic [7:0] DEMO_OFFSET      = 8'd30;
  localparam logic [7:0] PROJECTION_LIMIT = 8'd180;

  // Configuration register reset values.
  localparam logic [7:0] MOTION_THR_RESET = 8'd30;
  localparam logic [7:0] HIT_EXTRA_RESET  = 8'd40;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MOTION_THR = 2'd0,
    CFG_HIT_EXTRA  = 2'd1,
    CFG_DEMO_MODE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] motion_threshold;
    logic [7:0] hit_extra_threshold;
    logic       demo_offset_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] filtered_gray;
    logic [7:0] abs_difference;
    logic       motion_pixel;
    logic       hit_pixel;
  } result_t;

endpackage

/* design/background_subtract_pixel_pipe.sv */
// ----------------------------------------------------------------------------
// background_subtract_pixel_pipe
// Per-pixel gray conversion, background learning and motion classification.
// ----------------------------------------------------------------------------
// The pipe takes one pixel word per clock while not stalled and returns one
// result word per pixel. The pixel is registered on entry; its gray value
// is formed there and the background store is read (and, when learning in
// camera mode, written) at the edge into the second stage, whose registered
// read data is classified and placed in the output register. The store has
// one read and one write port, both used by the same pixel, so one pixel per
// clock is sustained when no stall holds the pipe.
// Stalls propagate back through the three stages so that every stage keeps
// filling while a finished result waits. The background store is not
// cleared at reset: each entry must be learned before it is used, and a
// pixel index at or beyond the frame size stores nothing and compares
// against a zero background. Configuration should be written only while
// the pipe is empty.
// ----------------------------------------------------------------------------
module background_subtract_pixel_pipe (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [7:0]                cfg_wdata,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  input  logic [bsp_pkg::IDX_W-1:0] in_pixel_index,
  input  logic                      in_learn,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_filtered_gray,
  output logic [7:0]                out_abs_difference,
  output logic                      out_motion_pixel,
  output logic                      out_hit_pixel
);
  import bsp_pkg::*;

  // Configuration registers.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_threshold    <= MOTION_THR_RESET;
      cfg_r.hit_extra_threshold <= HIT_EXTRA_RESET;
      cfg_r.demo_offset_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MOTION_THR: cfg_r.motion_threshold    <= cfg_wdata;
        CFG_HIT_EXTRA:  cfg_r.hit_extra_threshold <= cfg_wdata;
        CFG_DEMO_MODE:  cfg_r.demo_offset_mode    <= cfg_wdata[0];
        default:        ; // Unknown indexes are ignored.
      endcase
    end
  end

  // Handshake: each stage moves on when the stage after it can take a word.
  logic a_valid_r;
  logic b_valid_r;
  logic out_valid_r;
  logic out_ready;
  logic b_ready;
  logic a_ready;
  logic a_adv;
  logic b_adv;

  assign out_ready = !out_valid_r || !out_stall;
  assign b_ready   = !b_valid_r || out_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign a_adv     = a_valid_r && b_ready;
  assign b_adv     = b_valid_r && out_ready;
  assign in_stall  = !a_ready;

  // Stage A: registered input pixel.
  logic [7:0]       a_red_r;
  logic [7:0]       a_green_r;
  logic [7:0]       a_blue_r;
  logic [IDX_W-1:0] a_idx_r;
  logic             a_learn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_red_r   <= in_red;
      a_green_r <= in_green;
      a_blue_r  <= in_blue;
      a_idx_r   <= in_pixel_index;
      a_learn_r <= in_learn;
    end
  end

  logic [7:0] a_gray;
  logic       a_in_range;
  logic       a_store;

  bsp_gray_conv u_gray (
    .red   (a_red_r),
    .green (a_green_r),
    .blue  (a_blue_r),
    .gray  (a_gray)
  );

  assign a_in_range = ({15'd0, a_idx_r} < 32'(FRAME_PIXELS));
  // Learning happens only from the camera source.
  assign a_store    = a_learn_r && !cfg_r.demo_offset_mode && a_in_range;

  // The store is read and written by the same pixel at the same edge; that
  // pixel's own write is picked up below, all earlier writes are already
  // in the array.
  logic [7:0] mem_rd_data;

  bsp_bg_mem u_mem (
    .clk     (clk),
    .wr_en   (a_adv && a_store),
    .wr_addr (a_idx_r),
    .wr_data (a_gray),
    .rd_en   (a_adv && a_in_range),
    .rd_addr (a_idx_r),
    .rd_data (mem_rd_data)
  );

  // Stage B: gray value and background read data.
  logic [7:0] b_gray_r;
  logic       b_in_range_r;
  logic       b_stored_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_gray_r     <= a_gray;
      b_in_range_r <= a_in_range;
      b_stored_r   <= a_store;
    end
  end

  logic [7:0] b_background;
  result_t    b_result;

  always_comb begin
    if (b_stored_r) begin
      b_background = b_gray_r;
    end else if (b_in_range_r) begin
      b_background = mem_rd_data;
    end else begin
      b_background = 8'd0;
    end
  end

  bsp_classify u_classify (
    .gray       (b_gray_r),
    .background (b_background),
    .cfg        (cfg_r),
    .result     (b_result)
  );

  // Output register.
  result_t out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_result_r <= b_result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_gray  = out_result_r.filtered_gray;
  assign out_abs_difference = out_result_r.abs_difference;
  assign out_motion_pixel   = out_result_r.motion_pixel;
  assign out_hit_pixel      = out_result_r.hit_pixel;

endmodule

/* design/bsp_gray_conv.sv */
// ----------------------------------------------------------------------------
// bsp_gray_conv
// Weighted RGB to gray conversion, truncated to eight bits.
// ----------------------------------------------------------------------------
module bsp_gray_conv (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] gray
);
  import bsp_pkg::*;

  logic [GRAY_SUM_W-1:0] sum;

  // The largest sum is 32 * 255, which fits in thirteen bits.
  assign sum = ({{(GRAY_SUM_W-8){1'b0}}, red}   * GRAY_WEIGHT_R)
             + ({{(GRAY_SUM_W-8){1'b0}}, green} * GRAY_WEIGHT_G)
             + ({{(GRAY_SUM_W-8){1'b0}}, blue}  * GRAY_WEIGHT_B);

  assign gray = sum[GRAY_SHIFT +: 8];

endmodule

/* design/bsp_bg_mem.sv */
// ----------------------------------------------------------------------------
// bsp_bg_mem
// Background frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bsp_bg_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [bsp_pkg::IDX_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [bsp_pkg::IDX_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import bsp_pkg::*;

  logic [7:0] mem [FRAME_PIXELS];
  logic [7:0] rd_data_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/bsp_classify.sv */
// ----------------------------------------------------------------------------
// bsp_classify
// Demo offset, projection replacement, absolute difference and thresholds.
// ----------------------------------------------------------------------------
module bsp_classify (
  input  logic [7:0]       gray,
  input  logic [7:0]       background,
  input  bsp_pkg::cfg_t    cfg,
  output bsp_pkg::result_t result
);
  import bsp_pkg::*;

  logic [7:0] offset_gray;
  logic [7:0] filt;
  logic [7:0] diff;
  logic [8:0] hit_limit;

  always_comb begin
    offset_gray = cfg.demo_offset_mode ? (gray - DEMO_OFFSET) : gray;
    filt        = (offset_gray > PROJECTION_LIMIT) ? background : offset_gray;
    diff        = (background > filt) ? (background - filt) : (filt - background);
    // Nine-bit sum, so it never wraps.
    hit_limit   = {1'b0, cfg.motion_threshold} + {1'b0, cfg.hit_extra_threshold};

    result.filtered_gray  = filt;
    result.abs_difference = diff;
    result.motion_pixel   = (diff > cfg.motion_threshold);
    result.hit_pixel      = ({1'b0, diff} > hit_limit);
  end

endmodule
